>>> sv/button_event_queue_masked_take_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button event queue
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EVENT_QUEUE_MASKED_TAKE_MACROS_SVH
`define BUTTON_EVENT_QUEUE_MASKED_TAKE_MACROS_SVH

// same-cycle implication
`define BEMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bemt_pkg.sv
// ---------------------------------------------------------------------------
// bemt_pkg
// Types and constants shared by the button event queue and its cells.
// ---------------------------------------------------------------------------
package bemt_pkg;

	localparam int CODE_BITS = 10;
	localparam int FILL_BITS = 4;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef logic [CODE_BITS-1:0] code_t;

	typedef struct packed {
		logic  cmd;
		code_t button_code;
		code_t take_mask;
	} bemt_req_t;

	typedef struct packed {
		logic                 found;
		code_t                taken_code;
		logic                 dropped_oldest;
		logic [FILL_BITS-1:0] fill_level;
	} bemt_res_t;

	// broadcast control to every cell
	typedef struct packed {
		logic  append;  // nonzero push, room left
		logic  drop;    // nonzero push, queue full: shift all
		logic  take;
		code_t code;
		code_t mask;
	} bemt_ctl_t;

	// search chain passed from older to younger cell
	typedef struct packed {
		logic  hit;
		code_t code;
	} bemt_chain_t;

endpackage

>>> sv/bemt_cell.sv
// ---------------------------------------------------------------------------
// bemt_cell
// One queue slot: holds a code, takes part in the oldest-first masked
// search and shifts toward the oldest end when an older slot is removed.
// ---------------------------------------------------------------------------
module bemt_cell (
	input  logic                clk,
	input  bemt_pkg::bemt_ctl_t ctl,
	input  logic                valid,
	input  logic                tail,
	input  bemt_pkg::code_t     younger,
	input  bemt_pkg::bemt_chain_t chain_in,
	output bemt_pkg::bemt_chain_t chain_out,
	output bemt_pkg::code_t     code
);
	import bemt_pkg::*;

	code_t code_q;
	logic  match;
	logic  here;

	always_comb begin
		match          = valid && ((code_q & ~ctl.mask) == '0);
		here           = match && !chain_in.hit;
		chain_out.hit  = chain_in.hit || match;
		chain_out.code = chain_in.code | (here ? code_q : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.drop || (ctl.take && chain_out.hit)) begin
			code_q <= younger;
		end else if (ctl.append && tail) begin
			code_q <= ctl.code;
		end
	end

	assign code = code_q;

endmodule

>>> sv/button_event_queue_masked_take.sv
// ---------------------------------------------------------------------------
// button_event_queue_masked_take
// Bounded oldest-first queue of button codes with masked take.
// ---------------------------------------------------------------------------
// Usage:
//  - A transaction is issued by raising start with req valid; it is taken at
//    the rising edge where start is high and busy is low. busy stays low, so
//    a new transaction may be issued every cycle.
//  - req.cmd selects push (append a nonzero code, dropping the oldest when
//    full) or take (remove the oldest entry whose bits all lie in take_mask).
//    A push of zero changes nothing but still returns a result.
//  - Exactly one result per transaction: done pulses for one cycle, the cycle
//    after acceptance, with result valid. Throughput one transaction per
//    cycle.
//  - The queue is a row of QUEUE_DEPTH cells, oldest at cell 0. The search
//    ripples a hit flag from oldest to youngest through the cells, which sets
//    the combinational path; removal shifts each younger cell one place down.
//  - Only the fill count and done are reset; cell contents are never read above it.
//  - The receiver cannot stall: a result not taken in its cycle is lost.
// ---------------------------------------------------------------------------
module button_event_queue_masked_take #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bemt_pkg::bemt_req_t req,
	output logic                done,
	output bemt_pkg::bemt_res_t result
);
	import bemt_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                     accept;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic                     full;
	bemt_ctl_t                ctl;
	bemt_chain_t              chain [QUEUE_DEPTH+1];
	code_t                    cell_code [QUEUE_DEPTH];
	logic                     found;
	logic [CW+FILL_BITS-1:0]  fill_wide;
	logic                     done_q;
	bemt_res_t                result_q;

	// busy is never raised: the design never stalls a transaction
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(QUEUE_DEPTH));

	always_comb begin
		ctl        = '0;
		ctl.code   = req.button_code;
		ctl.mask   = req.take_mask;
		if (accept) begin
			case (req.cmd)
				CMD_PUSH: begin
					ctl.append = (req.button_code != '0) && !full;
					ctl.drop   = (req.button_code != '0) && full;
				end
				CMD_TAKE: begin
					ctl.take   = 1'b1;
				end
				default: begin
					ctl.take   = 1'b0;
				end
			endcase
		end
	end

	// search chain enters empty at the oldest end
	assign chain[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		code_t younger;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign younger = ctl.code;  // drop shifts the new code into the tail
		end else begin : g_mid
			assign younger = cell_code[i+1];
		end
		bemt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (CW'(i) < count_q),
			.tail      (CW'(i) == count_q),
			.younger   (younger),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.code      (cell_code[i])
		);
	end

	assign found = ctl.take && chain[QUEUE_DEPTH].hit;

	always_comb begin
		count_d = count_q;
		if (ctl.append) begin
			count_d = count_q + CW'(1);
		end else if (found) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	assign fill_wide = {{FILL_BITS{1'b0}}, count_d};

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.found          <= found;
			result_q.taken_code     <= found ? chain[QUEUE_DEPTH].code : '0;
			result_q.dropped_oldest <= ctl.drop;
			result_q.fill_level     <= fill_wide[FILL_BITS-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

`include "button_event_queue_masked_take_macros.svh"

	`BEMT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH), "fill count above depth")
	`BEMT_ASSERT_NEXT(a_done_follows, accept, done, "result strobe missing after transaction")
	`BEMT_ASSERT_NEXT(a_no_spurious, !accept, !done, "result strobe without transaction")
	`BEMT_ASSERT_NEXT(a_drop_full, ctl.drop, count_q == CW'(QUEUE_DEPTH), "drop left queue not full")
	`BEMT_ASSERT_NOW(a_take_noinc, ctl.take, count_d <= count_q, "take grew the queue")

endmodule
